// ----- rtl/edfptf_pkg.sv -----
`default_nettype none
package edfptf_pkg;

  localparam int          NUM_CPUS_DEF   = 64;
  localparam int          MAX_MASK_CPUS  = 64;
  localparam int          DL_W           = 64;
  localparam int          CPU_W          = 6;
  localparam int          CCOUNT_W       = 7;

  localparam logic [CCOUNT_W-1:0] CPU_COUNT_RST = 7'd12;
  localparam logic [63:0]         ISO_MASK_RST  = 64'd2080;

  // event codes
  localparam logic OP_RUN   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_CPU_COUNT = 1'b0;
  localparam logic CFG_ISO_MASK  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/edfptf_ram.sv -----
`default_nettype none
module edfptf_ram #(
  parameter int  W     = 64,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/edf_preempt_target_finder.sv -----
`default_nettype none
// EDF preemption target finder.
// Input channel (in_valid / in_stall) takes one event per request: a running
// event (in_opcode = run) stores in_task_deadline for in_cpu_index when that
// cpu is isolated; a query (in_opcode = query) looks for the isolated cpu with
// the latest stored deadline below cpu_count and reports it when the queried
// deadline is earlier. Every request gives exactly one result on the output
// channel (out_valid / out_stall); running events report no target.
// A running event passes through S_DONE to the output register; a query
// first scans min(cpu_count, table depth) entries, or none when cpu_count is 0.
// The table sits in a one-port-write, one-port-read ram with registered read,
// scanned one entry per cycle by a single 64-bit comparator that also makes
// the final decision.
// The block handles one request at a time; in_stall is high while it works.
// A finished result waits in the output register while out_stall is high;
// the next request is still taken, but its result waits for the slot.
// Reset (rst_n low, synchronous) empties the table through per-entry valid
// bits, so no clearing pass is needed; cpu_count returns to 12 and the
// isolated mask to cpus 5 and 11. cfg writes are always ready.
module edf_preempt_target_finder
  import edfptf_pkg::*;
#(
  parameter int NUM_CPUS = NUM_CPUS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_opcode,
  input  wire logic [CPU_W-1:0] in_cpu_index,
  input  wire logic [DL_W-1:0]  in_task_deadline,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_target_valid,
  output logic [CPU_W-1:0]      out_target_cpu,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [DL_W-1:0]  cfg_wdata
);

  localparam int TBL_DEPTH = (NUM_CPUS < MAX_MASK_CPUS) ? NUM_CPUS : MAX_MASK_CPUS;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int CW        = $clog2(TBL_DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;
  logic [DL_W-1:0]      dl_r, dl_nxt;
  logic                 isq_r, isq_nxt;
  logic [DL_W-1:0]      best_r, best_nxt;
  logic [CPU_W-1:0]     bcpu_r, bcpu_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic                 p_iso_r, p_iso_nxt;
  logic [AW-1:0]        p_idx_r, p_idx_nxt;
  logic [TBL_DEPTH-1:0] vld_r, vld_nxt;
  logic [63:0]          mask_r;
  logic [CCOUNT_W-1:0]  ccount_r;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_tv_r, out_tv_nxt;
  logic [CPU_W-1:0]     out_cpu_r, out_cpu_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [DL_W-1:0]      ram_rdata;
  logic [DL_W-1:0]      cmp_a, cmp_b;
  logic                 gt;
  logic [CW-1:0]        lim_calc;

  edfptf_ram #(
    .W     (DL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_task_deadline),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign in_accept        = in_valid && !in_stall;
  assign out_valid        = out_vld_r;
  assign out_target_valid = out_tv_r;
  assign out_target_cpu   = out_cpu_r;
  assign cfg_ready        = 1'b1;
  assign out_free         = !out_vld_r || !out_stall;

  // running event stores only for an isolated cpu inside the table
  assign ram_waddr = in_cpu_index[AW-1:0];
  assign ram_we    = in_accept && (in_opcode == OP_RUN)
                     && ({1'b0, in_cpu_index} < CCOUNT_W'(TBL_DEPTH))
                     && mask_r[in_cpu_index];

  assign lim_calc = (ccount_r > CCOUNT_W'(TBL_DEPTH)) ? CW'(TBL_DEPTH) : CW'(ccount_r);

  // shared comparator: scan step, then final decision
  assign cmp_a = (state_r == S_DONE) ? best_r : ram_rdata;
  assign cmp_b = (state_r == S_DONE) ? dl_r   : best_r;
  assign gt    = cmp_a > cmp_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vld_r     <= '0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      mask_r    <= ISO_MASK_RST;
      ccount_r  <= CPU_COUNT_RST;
    end else begin
      state_r   <= state_nxt;
      vld_r     <= vld_nxt;
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CPU_COUNT: ccount_r <= cfg_wdata[CCOUNT_W-1:0];
          CFG_ISO_MASK:  mask_r   <= cfg_wdata;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    lim_r     <= lim_nxt;
    dl_r      <= dl_nxt;
    isq_r     <= isq_nxt;
    best_r    <= best_nxt;
    bcpu_r    <= bcpu_nxt;
    p_iso_r   <= p_iso_nxt;
    p_idx_r   <= p_idx_nxt;
    out_tv_r  <= out_tv_nxt;
    out_cpu_r <= out_cpu_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    lim_nxt     = lim_r;
    dl_nxt      = dl_r;
    isq_nxt     = isq_r;
    best_nxt    = best_r;
    bcpu_nxt    = bcpu_r;
    p_vld_nxt   = 1'b0;
    p_iso_nxt   = p_iso_r;
    p_idx_nxt   = p_idx_r;
    vld_nxt     = vld_r;
    out_vld_nxt = out_vld_r && out_stall;
    out_tv_nxt  = out_tv_r;
    out_cpu_nxt = out_cpu_r;
    ram_raddr   = cnt_r[AW-1:0];

    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end

    // compare stage, in the cycle after the read is issued
    if (p_vld_r && p_iso_r && gt) begin
      best_nxt = ram_rdata;
      bcpu_nxt = CPU_W'(p_idx_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          isq_nxt  = (in_opcode == OP_QUERY);
          dl_nxt   = in_task_deadline;
          best_nxt = '0;
          bcpu_nxt = '0;
          cnt_nxt  = '0;
          lim_nxt  = lim_calc;
          if ((in_opcode == OP_QUERY) && (lim_calc != '0)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        p_vld_nxt = 1'b1;
        p_iso_nxt = mask_r[cnt_r[AW-1:0]] && vld_r[cnt_r[AW-1:0]];
        p_idx_nxt = cnt_r[AW-1:0];
        if (CW'(cnt_r + 1'b1) == lim_r) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = CW'(cnt_r + 1'b1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // best above the queried deadline implies a nonzero best
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_tv_nxt  = isq_r && gt;
          out_cpu_nxt = (isq_r && gt) ? bcpu_r : '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
